FILE: rtl/core/wufm_pkg.sv
package wufm_pkg;

  localparam int unsigned NODE_W  = 16;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic REL_SAME = 1'b0;
  localparam logic REL_EATS = 1'b1;

  typedef logic [1:0] mod3_t;

  typedef struct packed {
    logic valid;
    logic bad;
  } res_t;

  // Sum of two residues in the range zero to two, reduced modulo three.
  function automatic mod3_t mod3_add(input mod3_t x, input mod3_t y);
    logic [2:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  // Additive inverse modulo three.
  function automatic mod3_t mod3_neg(input mod3_t x);
    mod3_t r;
    case (x)
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/wufm_mem.sv
module wufm_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wparent_i,
  input  logic [1:0]    woff_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rparent_o,
  output logic [1:0]    roff_o
);

  logic [AW+1:0] mem_q [DEPTH];
  logic [AW+1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wparent_i, woff_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rparent_o = rdata_q[AW+1:2];
  assign roff_o    = rdata_q[1:0];

endmodule

FILE: rtl/core/wufm_ctrl.sv
module wufm_ctrl
  import wufm_pkg::*;
#(
  parameter int unsigned MAX_NODES = 65536,
  parameter int unsigned AW        = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              relation_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  input  logic [NODE_W-1:0] node_count_i,
  input  logic              res_free_i,
  output res_t              res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [AW-1:0]     mem_wparent_o,
  output logic [1:0]        mem_woff_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [AW-1:0]     mem_rparent_i,
  input  logic [1:0]        mem_roff_i
);

  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_PACK  = 7'b0001000,
    S_WANT  = 7'b0010000,
    S_JOIN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] root_q, root_d;
  logic [AW-1:0] ra_q, ra_d;
  logic [AW-1:0] nb_q, nb_d;
  mod3_t         pot_q, pot_d;
  mod3_t         t_q, t_d;
  mod3_t         pa_q, pa_d;
  mod3_t         want_q, want_d;
  logic          rel_q, rel_d;
  logic          which_q, which_d;
  logic          bad_q, bad_d;

  mod3_t         alu_x, alu_y, alu_s;
  logic          fin;
  logic [AW-1:0] root_n;
  logic          range_bad;

  assign alu_s = mod3_add(alu_x, alu_y);

  assign range_bad = (node_a_i > node_count_i) || (node_b_i > node_count_i) ||
                     (32'(node_a_i) >= MAX_NODES) || (32'(node_b_i) >= MAX_NODES);

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    start_d       = start_q;
    root_d        = root_q;
    ra_d          = ra_q;
    nb_d          = nb_q;
    pot_d         = pot_q;
    t_d           = t_q;
    pa_d          = pa_q;
    want_d        = want_q;
    rel_d         = rel_q;
    which_d       = which_q;
    bad_d         = bad_q;
    alu_x         = pot_q;
    alu_y         = mem_roff_i;
    fin           = 1'b0;
    root_n        = root_q;
    in_ready_o    = 1'b0;
    res_o         = '0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = cur_q;
    mem_wparent_o = root_q;
    mem_woff_o    = t_q;
    mem_raddr_o   = cur_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o      = 1'b1;
        mem_waddr_o   = cur_q;
        mem_wparent_o = cur_q;
        mem_woff_o    = '0;
        cur_d         = cur_q + AW'(1);
        if (cur_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = AW'(node_a_i);
        if (in_valid_i) begin
          rel_d   = relation_i;
          start_d = AW'(node_a_i);
          cur_d   = AW'(node_a_i);
          nb_d    = AW'(node_b_i);
          pot_d   = '0;
          which_d = 1'b0;
          bad_d   = 1'b0;
          if (range_bad || (relation_i == REL_EATS && node_a_i == node_b_i)) begin
            bad_d   = 1'b1;
            state_d = S_DONE;
          end else if (node_a_i == node_b_i) begin
            state_d = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        alu_x = pot_q;
        alu_y = mem_roff_i;
        if (mem_rparent_i == cur_q) begin
          root_n = cur_q;
          root_d = cur_q;
          t_d    = pot_q;
          cur_d  = start_q;
          if (start_q == cur_q) begin
            fin = 1'b1;
          end else begin
            mem_raddr_o = start_q;
            state_d     = S_PACK;
          end
        end else begin
          mem_raddr_o = mem_rparent_i;
          cur_d       = mem_rparent_i;
          pot_d       = alu_s;
        end
      end
      S_PACK: begin
        alu_x         = t_q;
        alu_y         = mod3_neg(mem_roff_i);
        mem_we_o      = 1'b1;
        mem_waddr_o   = cur_q;
        mem_wparent_o = root_q;
        mem_woff_o    = t_q;
        t_d           = alu_s;
        cur_d         = mem_rparent_i;
        if (mem_rparent_i == root_q) begin
          fin = 1'b1;
        end else begin
          mem_raddr_o = mem_rparent_i;
        end
      end
      S_WANT: begin
        alu_x   = {1'b0, rel_q};
        alu_y   = pot_q;
        want_d  = alu_s;
        state_d = S_JOIN;
      end
      S_JOIN: begin
        alu_x = pa_q;
        alu_y = mod3_neg(want_q);
        if (ra_q == root_q) begin
          bad_d = (want_q != pa_q);
        end else begin
          mem_we_o      = 1'b1;
          mem_waddr_o   = root_q;
          mem_wparent_o = ra_q;
          mem_woff_o    = alu_s;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        res_o.valid = 1'b1;
        res_o.bad   = bad_q;
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The walk of the first node hands over to the walk of the second.
    if (fin) begin
      if (!which_q) begin
        ra_d        = root_n;
        pa_d        = pot_q;
        which_d     = 1'b1;
        start_d     = nb_q;
        cur_d       = nb_q;
        pot_d       = '0;
        mem_raddr_o = nb_q;
        state_d     = S_WALK;
      end else begin
        state_d = S_WANT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cur_q   <= '0;
      which_q <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      which_q <= which_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    root_q  <= root_d;
    ra_q    <= ra_d;
    nb_q    <= nb_d;
    pot_q   <= pot_d;
    t_q     <= t_d;
    pa_q    <= pa_d;
    want_q  <= want_d;
    rel_q   <= rel_d;
  end

endmodule

FILE: rtl/core/weighted_union_find_mod3.sv
// Channel  Handshake                  Word
// in       in_valid_i / in_ready_o    relation_i, node_a_i, node_b_i
// out      out_valid_o / out_ready_i  statement_false_o, false_total_o
// cfg      cfg_we_i                   cfg_wdata_i (node_count)
//
// After reset the link memory is initialized entry by entry for all MAX_NODES
// entries before the first word is taken. A statement that is rejected or
// trivially true goes straight to its result; else both finds and their path
// compression read each parent link through the single memory read port.
// The result register lets a new word in while the previous result waits.
module weighted_union_find_mod3
  import wufm_pkg::*;
#(
  parameter int unsigned MAX_NODES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               relation_i,
  input  logic [NODE_W-1:0]  node_a_i,
  input  logic [NODE_W-1:0]  node_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               statement_false_o,
  output logic [TOTAL_W-1:0] false_total_o,
  input  logic               cfg_we_i,
  input  logic [NODE_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  logic [NODE_W-1:0]  node_count_q;
  logic [TOTAL_W-1:0] total_q;
  logic               out_valid_q;
  logic               bad_q;
  logic               res_free;
  res_t               res;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_wparent, mem_raddr, mem_rparent;
  logic [1:0]    mem_woff, mem_roff;

  assign res_free = !out_valid_q || out_ready_i;

  wufm_mem #(
    .DEPTH(MAX_NODES),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wparent_i(mem_wparent),
    .woff_i   (mem_woff),
    .raddr_i  (mem_raddr),
    .rparent_o(mem_rparent),
    .roff_o   (mem_roff)
  );

  wufm_ctrl #(
    .MAX_NODES(MAX_NODES),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .relation_i   (relation_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .node_count_i (node_count_q),
    .res_free_i   (res_free),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wparent_o(mem_wparent),
    .mem_woff_o   (mem_woff),
    .mem_raddr_o  (mem_raddr),
    .mem_rparent_i(mem_rparent),
    .mem_roff_i   (mem_roff)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= {NODE_W{1'b1}};
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      bad_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (res.valid && res_free) begin
        out_valid_q <= 1'b1;
        bad_q       <= res.bad;
        if (res.bad && total_q != TOTAL_MAX) begin
          total_q <= total_q + TOTAL_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign statement_false_o = bad_q;
  assign false_total_o     = total_q;

endmodule

FILE: test/tb_weighted_union_find_mod3.sv
`timescale 1ns / 100ps

module tb_weighted_union_find_mod3;
  import wufm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned NODE_SPAN   = 1 << NODE_W;

  class statement_judge;
    typedef struct {
      bit               lie;
      bit [TOTAL_W-1:0] total;
    } verdict_t;

    bit [NODE_W-1:0]  link[NODE_SPAN];
    bit [1:0]         pot[NODE_SPAN];
    bit [TOTAL_W-1:0] lies_seen;
    bit [NODE_W-1:0]  node_limit;
    verdict_t         awaited_verdicts[$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < NODE_SPAN; i++) begin
        link[i] = NODE_W'(i);
        pot[i]  = 2'd0;
      end
      lies_seen  = '0;
      node_limit = '1;
      mismatches = 0;
    endfunction

    function void set_limit(input bit [NODE_W-1:0] v);
      node_limit = v;
    endfunction

    function int unsigned pending();
      return awaited_verdicts.size();
    endfunction

    function bit [NODE_W-1:0] root_of(input bit [NODE_W-1:0] v, output int unsigned p);
      bit [NODE_W-1:0] cur;
      cur = v;
      p   = 0;
      while (link[cur] != cur) begin
        p   = (p + pot[cur]) % 3;
        cur = link[cur];
      end
      return cur;
    endfunction

    function void note_statement(input logic rel, input bit [NODE_W-1:0] a,
                                 input bit [NODE_W-1:0] b);
      bit              bad;
      bit [NODE_W-1:0] ra, rb;
      int unsigned     pa, pb, want;
      verdict_t        v;
      bad = 1'b0;
      if (a > node_limit || b > node_limit) begin
        bad = 1'b1;
      end else if (rel == REL_EATS && a == b) begin
        bad = 1'b1;
      end else begin
        ra   = root_of(a, pa);
        rb   = root_of(b, pb);
        want = ((rel == REL_EATS ? 1 : 0) + pb) % 3;
        if (ra == rb) begin
          bad = (want != pa);
        end else begin
          link[rb] = ra;
          pot[rb]  = 2'((pa + 3 - want) % 3);
        end
      end
      if (bad && lies_seen != TOTAL_MAX) begin
        lies_seen++;
      end
      v.lie   = bad;
      v.total = lies_seen;
      awaited_verdicts.push_back(v);
    endfunction

    function void check_verdict(input logic lie, input logic [TOTAL_W-1:0] total);
      verdict_t v;
      if (awaited_verdicts.size() == 0) begin
        $error("unexpected result word: statement_false %0d, false_total %0d", lie, total);
        mismatches++;
        return;
      end
      v = awaited_verdicts.pop_front();
      if (lie !== v.lie) begin
        $error("statement_false: expected %0d, actual %0d", v.lie, lie);
        mismatches++;
      end
      if (total !== v.total) begin
        $error("false_total: expected %0d, actual %0d", v.total, total);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               relation_i;
  logic [NODE_W-1:0]  node_a_i;
  logic [NODE_W-1:0]  node_b_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               statement_false_o;
  logic [TOTAL_W-1:0] false_total_o;
  logic               cfg_we_i;
  logic [NODE_W-1:0]  cfg_wdata_i;

  statement_judge judge;
  int unsigned    burst_left;
  int unsigned    ready_hold;
  int unsigned    ready_mode;
  int unsigned    ready_mode_left;
  int unsigned    cycles;

  weighted_union_find_mod3 u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .relation_i        (relation_i),
    .node_a_i          (node_a_i),
    .node_b_i          (node_b_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .statement_false_o (statement_false_o),
    .false_total_o     (false_total_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("weighted_union_find_mod3 regression: fail");
      $finish;
    end
  end

  // The receiver switches between always ready, per-cycle random and long stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        judge.check_verdict(statement_false_o, false_total_o);
      end
      if (ready_mode_left == 0) begin
        ready_mode      = $urandom_range(0, 2);
        ready_mode_left = $urandom_range(50, 300);
      end else begin
        ready_mode_left--;
      end
      if (ready_hold != 0) begin
        ready_hold--;
      end else begin
        case (ready_mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_ready_i <= ~out_ready_i;
            ready_hold = $urandom_range(0, 15);
          end
        endcase
      end
    end
  end

  task automatic send_statement(input logic rel, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    relation_i <= rel;
    node_a_i   <= a;
    node_b_i   <= b;
    do @(posedge clk_i); while (!in_ready_o);
    judge.note_statement(rel, a, b);
    burst_left--;
  endtask

  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    while (judge.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [NODE_W-1:0] v);
    drain_verdicts();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    judge.set_limit(v);
  endtask

  function automatic logic [NODE_W-1:0] pick_node(input logic [NODE_W-1:0] limit);
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(0, 99);
    span = (limit < 40) ? 32'(limit) : 40;
    if (r < 8) begin
      return NODE_W'($urandom_range(0, NODE_SPAN - 1));
    end else if (r < 14 && limit < NODE_SPAN - 8) begin
      return NODE_W'(32'(limit) + $urandom_range(1, 6));
    end else if (r < 30 && limit == NODE_SPAN - 1) begin
      return NODE_W'((NODE_SPAN - 1) - $urandom_range(0, 40));
    end
    return NODE_W'($urandom_range(0, span));
  endfunction

  task automatic random_phase(input logic [NODE_W-1:0] limit, input int unsigned count);
    logic rel;
    for (int i = 0; i < count; i++) begin
      rel = ($urandom_range(0, 1) == 1) ? REL_EATS : REL_SAME;
      send_statement(rel, pick_node(limit), pick_node(limit));
    end
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    relation_i      = REL_SAME;
    node_a_i        = '0;
    node_b_i        = '0;
    out_ready_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    burst_left      = 0;
    ready_hold      = 0;
    ready_mode      = 0;
    ready_mode_left = 0;
    cycles          = 0;
    judge           = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_node_count(16'hFFFF);
    send_statement(REL_SAME, 16'd0, 16'd0);
    send_statement(REL_EATS, 16'd5, 16'd5);
    send_statement(REL_EATS, 16'd0, 16'd1);
    send_statement(REL_EATS, 16'd1, 16'd2);
    send_statement(REL_EATS, 16'd2, 16'd0);
    send_statement(REL_EATS, 16'd0, 16'd2);
    send_statement(REL_SAME, 16'd0, 16'd1);
    send_statement(REL_SAME, 16'hFFFF, 16'hFFFF);
    send_statement(REL_EATS, 16'hFFFF, 16'd0);
    send_statement(REL_SAME, 16'hFFFE, 16'hFFFF);
    send_statement(REL_EATS, 16'd0, 16'hFFFE);
    send_statement(REL_EATS, 16'd2, 16'hFFFF);

    write_node_count(16'd0);
    send_statement(REL_SAME, 16'd0, 16'd0);
    send_statement(REL_EATS, 16'd0, 16'd0);
    send_statement(REL_SAME, 16'd1, 16'd0);
    send_statement(REL_SAME, 16'd0, 16'd1);

    write_node_count(16'd1);
    send_statement(REL_EATS, 16'd0, 16'd1);
    send_statement(REL_EATS, 16'd1, 16'd0);
    send_statement(REL_SAME, 16'd2, 16'd1);
    send_statement(REL_EATS, 16'hFFFF, 16'd0);

    write_node_count(16'hFFFF);
    random_phase(16'hFFFF, 160);
    write_node_count(16'd40);
    random_phase(16'd40, 140);
    write_node_count(16'd1);
    random_phase(16'd1, 40);
    write_node_count(16'd500);
    random_phase(16'd500, 120);
    write_node_count(16'd0);
    random_phase(16'd0, 30);
    write_node_count(16'hFFFF);
    random_phase(16'hFFFF, 210);

    drain_verdicts();
    repeat (20) @(posedge clk_i);
    if (judge.mismatches == 0 && judge.pending() == 0) begin
      $display("weighted_union_find_mod3 regression: pass");
    end else begin
      $display("weighted_union_find_mod3 regression: fail");
    end
    $finish;
  end

endmodule
